FILE: rtl/core/bta_pkg.sv
package bta_pkg;

    localparam int NUM_DIGITS  = 10;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int BIN_W       = 32;
    localparam int HEX_W       = 16;
    localparam int HEX_CHARS   = 4;
    localparam int DEC16_CHARS = 5;
    localparam int DEC32_CHARS = 10;

    localparam logic [1:0] CMD_HEX16 = 2'd0;
    localparam logic [1:0] CMD_DEC16 = 2'd1;
    localparam logic [1:0] CMD_DEC32 = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    typedef logic [7:0] t_char;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
        logic [1:0]       cmd;
        logic [HEX_W-1:0] hex;
    } t_dd;

    function automatic t_char hex_char(input logic [3:0] nib);
        t_char c;
        if (nib < 4'd10) begin
            c = CHAR_ZERO + {4'h0, nib};
        end else begin
            c = CHAR_A + {4'h0, nib - 4'd10};
        end
        return c;
    endfunction

    function automatic t_char dec_char(input logic [3:0] digit);
        return CHAR_ZERO + {4'h0, digit};
    endfunction

endpackage

FILE: rtl/core/bta_if.sv
interface bta_in_if;
    import bta_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       cmd;
    logic [BIN_W-1:0] number;

    modport source (output valid, output cmd, output number, input ready);
    modport sink   (input valid, input cmd, input number, output ready);
endinterface

interface bta_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

FILE: rtl/core/bta_dd_stage.sv
module bta_dd_stage
    import bta_pkg::*;
#(
    parameter int STEPS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dd  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_dd  o_data
);

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    always_comb begin
        n_data = i_data;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
                if (n_data.bcd[4*d +: 4] >= 4'd5) begin
                    n_data.bcd[4*d +: 4] = n_data.bcd[4*d +: 4] + 4'd3;
                end
            end
            {n_data.bcd, n_data.bin} = {n_data.bcd[BCD_W-2:0], n_data.bin, 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

FILE: rtl/core/binary_to_ascii_digits_top.sv
// From input transaction to first character: 4 conversion stages of 8
// shift-add-3 steps each, then the character register.
// Throughput: one character per cycle while o_out.ready is high; an item gives
// 4, 5 or 10 characters (hex16, dec16, dec32), set by the character serializer.
// Reset (synchronous, active low) empties the pipeline and serializer.
module binary_to_ascii_digits_top
    import bta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bta_in_if.sink      i_in,
    bta_out_if.source   o_out
);

    localparam int STAGES = 4;
    localparam int STEPS  = BIN_W / STAGES;

    logic stg_valid [STAGES+1];
    logic stg_ready [STAGES+1];
    t_dd  stg_data  [STAGES+1];

    always_comb begin
        stg_data[0].bcd = '0;
        stg_data[0].bin = (i_in.cmd == CMD_DEC32) ? i_in.number
                                                  : {16'h0, i_in.number[HEX_W-1:0]};
        stg_data[0].cmd = i_in.cmd;
        stg_data[0].hex = i_in.number[HEX_W-1:0];
    end

    assign stg_valid[0] = i_in.valid && (i_in.cmd != CMD_NONE);
    assign i_in.ready   = stg_ready[0];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        bta_dd_stage #(
            .STEPS (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    t_char      r_chars [NUM_DIGITS];
    t_char      n_chars [NUM_DIGITS];
    logic [3:0] r_left;
    logic [3:0] n_left;
    logic       pop;
    logic       load;

    assign pop              = o_out.valid && o_out.ready;
    assign stg_ready[STAGES] = (r_left == 4'd0) || ((r_left == 4'd1) && o_out.ready);
    assign load             = stg_ready[STAGES] && stg_valid[STAGES];

    always_comb begin
        n_chars = r_chars;
        n_left  = r_left;
        if (load) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                n_chars[k] = CHAR_ZERO;
            end
            case (stg_data[STAGES].cmd)
                CMD_HEX16: begin
                    for (int k = 0; k < HEX_CHARS; k++) begin
                        n_chars[k] = hex_char(stg_data[STAGES].hex[4*(HEX_CHARS-1-k) +: 4]);
                    end
                    n_left = 4'(HEX_CHARS);
                end
                CMD_DEC16: begin
                    for (int k = 0; k < DEC16_CHARS; k++) begin
                        n_chars[k] = dec_char(stg_data[STAGES].bcd[4*(DEC16_CHARS-1-k) +: 4]);
                    end
                    n_left = 4'(DEC16_CHARS);
                end
                CMD_DEC32: begin
                    for (int k = 0; k < DEC32_CHARS; k++) begin
                        n_chars[k] = dec_char(stg_data[STAGES].bcd[4*(DEC32_CHARS-1-k) +: 4]);
                    end
                    n_left = 4'(DEC32_CHARS);
                end
                default: begin
                    n_left = 4'd0;
                end
            endcase
        end else if (pop) begin
            for (int k = 0; k < NUM_DIGITS - 1; k++) begin
                n_chars[k] = r_chars[k+1];
            end
            n_left = r_left - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else begin
            r_left <= n_left;
        end
        r_chars <= n_chars;
    end

    assign o_out.valid     = (r_left != 4'd0);
    assign o_out.char_code = r_chars[0];
    assign o_out.last      = (r_left == 4'd1);

endmodule
